// ===== src/col2im_accumulate_assert.svh =====
// Assertion macros used by the design file col2im_accumulate.sv.
`ifndef COL2IM_ACCUMULATE_ASSERT_SVH
`define COL2IM_ACCUMULATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define C2I_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define C2I_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define C2I_ASSERT(lbl, prop, msg)
`define C2I_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

// ===== src/c2i_pkg.sv =====
package c2i_pkg;

    localparam int KERNEL_ROWS = 3;
    localparam int KERNEL_COLS = 3;
    localparam int MAX_COL_DIM = 64;
    localparam int CHANNELS    = 4;
    localparam int DATA_WIDTH  = 16;

    localparam int STORE_DEPTH = CHANNELS * KERNEL_ROWS * KERNEL_COLS * MAX_COL_DIM * MAX_COL_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = (MAX_COL_DIM > 1) ? $clog2(MAX_COL_DIM) : 1;
    localparam int LIM_W       = $clog2(MAX_COL_DIM + 1);
    localparam int KR_W        = $clog2(KERNEL_ROWS + 1);
    localparam int KC_W        = $clog2(KERNEL_COLS + 1);
    localparam int NTAPS       = KERNEL_ROWS * KERNEL_COLS;
    localparam int SUM_W       = DATA_WIDTH + $clog2(NTAPS);

    localparam int STEP_W   = 4;
    localparam int STEP_MAX = 15;
    localparam int KDIM_MAX = (KERNEL_ROWS > KERNEL_COLS) ? KERNEL_ROWS : KERNEL_COLS;
    localparam int OFF_MAX  = (KDIM_MAX - 1) * STEP_MAX;
    localparam int OFF_W    = $clog2(OFF_MAX + 2);
    localparam int DIFF_W   = $clog2(OFF_MAX + STEP_MAX + 1) + 1;
    localparam int PIX_W    = 11;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam logic [2:0] REG_COL_ROWS      = 3'd0;
    localparam logic [2:0] REG_COL_COLS      = 3'd1;
    localparam logic [2:0] REG_PAD_ROWS      = 3'd2;
    localparam logic [2:0] REG_PAD_COLS      = 3'd3;
    localparam logic [2:0] REG_STRIDE_ROWS   = 3'd4;
    localparam logic [2:0] REG_STRIDE_COLS   = 3'd5;
    localparam logic [2:0] REG_DILATION_ROWS = 3'd6;
    localparam logic [2:0] REG_DILATION_COLS = 3'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [1:0]            channel;
        logic [1:0]            kernel_row;
        logic [1:0]            kernel_col;
        logic [5:0]            col_row;
        logic [5:0]            col_col;
        logic signed [15:0]    entry_value;
        logic [9:0]            image_row;
        logic [9:0]            image_col;
    } req_t;

    typedef struct packed {
        logic signed [15:0] pixel_sum;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        logic [6:0] col_rows;
        logic [6:0] col_cols;
        logic [3:0] pad_rows;
        logic [3:0] pad_cols;
        logic [3:0] stride_rows;
        logic [3:0] stride_cols;
        logic [3:0] dilation_rows;
        logic [3:0] dilation_cols;
    } cfg_t;

    typedef struct packed {
        logic             exact;
        logic [OFF_W-1:0] k;
    } tap_fit_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } tap_pos_t;

    // Finds k with diff + k*step in [0, step); exact when that value is zero.
    function automatic tap_fit_t tap_fit(input logic signed [DIFF_W-1:0] diff,
                                         input logic [STEP_W-1:0] step);
        tap_fit_t res;
        int       v;
        int       k;
        res = '0;
        for (k = 0; k <= OFF_MAX; k++)
        begin
            v = int'(diff) + k * int'(step);
            if (v >= 0 && v < int'(step))
            begin
                res.k     = OFF_W'(k);
                res.exact = (v == 0);
            end
        end
        return res;
    endfunction

    // One axis of a tap: the padded pixel is q*step + r, the tap sits off lower.
    function automatic tap_pos_t dim_tap(input logic [PIX_W-1:0]  q,
                                         input logic [STEP_W-1:0] r,
                                         input logic [OFF_W-1:0]  off,
                                         input logic [STEP_W-1:0] step,
                                         input logic [LIM_W-1:0]  lim);
        tap_pos_t                 res;
        tap_fit_t                 fit;
        logic signed [DIFF_W-1:0] diff;
        logic [PIX_W-1:0]         pos_full;
        diff     = DIFF_W'(r) - DIFF_W'(off);
        fit      = tap_fit(diff, step);
        pos_full = q - PIX_W'(fit.k);
        res.hit  = fit.exact && (q >= PIX_W'(fit.k)) && (pos_full < PIX_W'(lim));
        res.pos  = pos_full[POS_W-1:0];
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input int ch, input int kr, input int kc,
                                                     input int r, input int c);
        return ADDR_W'((((ch * KERNEL_ROWS + kr) * KERNEL_COLS + kc) * MAX_COL_DIM + r)
                       * MAX_COL_DIM + c);
    endfunction

endpackage

// ===== src/c2i_div.sv =====
module c2i_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [c2i_pkg::PIX_W-1:0]     dividend,
    input  logic [c2i_pkg::STEP_W-1:0]    divisor,
    output logic                          done,
    output logic [c2i_pkg::PIX_W-1:0]     quotient,
    output logic [c2i_pkg::STEP_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(c2i_pkg::PIX_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [c2i_pkg::PIX_W-1:0]     quo_reg, quo_next;
    logic [c2i_pkg::STEP_W-1:0]    rem_reg, rem_next;
    logic [c2i_pkg::STEP_W-1:0]    dsr_reg, dsr_next;
    logic [c2i_pkg::STEP_W:0]      trial;
    logic                          fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[c2i_pkg::PIX_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[c2i_pkg::PIX_W-2:0], fits};
            rem_next = fits ? c2i_pkg::STEP_W'(trial - {1'b0, dsr_reg})
                            : trial[c2i_pkg::STEP_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(c2i_pkg::PIX_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/c2i_store.sv =====
module c2i_store (
    input  logic                              clk,
    input  logic                              we,
    input  logic [c2i_pkg::ADDR_W-1:0]        waddr,
    input  logic [c2i_pkg::DATA_WIDTH-1:0]    wdata,
    input  logic                              re,
    input  logic [c2i_pkg::ADDR_W-1:0]        raddr,
    output logic [c2i_pkg::DATA_WIDTH-1:0]    rdata
);

    logic [c2i_pkg::DATA_WIDTH-1:0] mem [c2i_pkg::STORE_DEPTH];
    logic [c2i_pkg::DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/c2i_regs.sv =====
module c2i_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [c2i_pkg::PADDR_W-1:0]    paddr,
    input  logic [c2i_pkg::PDATA_W-1:0]    pwdata,
    output logic [c2i_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output c2i_pkg::cfg_t                  cfg
);

    c2i_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx   = paddr[c2i_pkg::PADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                c2i_pkg::REG_COL_ROWS:      cfg_next.col_rows      = pwdata[6:0];
                c2i_pkg::REG_COL_COLS:      cfg_next.col_cols      = pwdata[6:0];
                c2i_pkg::REG_PAD_ROWS:      cfg_next.pad_rows      = pwdata[3:0];
                c2i_pkg::REG_PAD_COLS:      cfg_next.pad_cols      = pwdata[3:0];
                c2i_pkg::REG_STRIDE_ROWS:   cfg_next.stride_rows   = pwdata[3:0];
                c2i_pkg::REG_STRIDE_COLS:   cfg_next.stride_cols   = pwdata[3:0];
                c2i_pkg::REG_DILATION_ROWS: cfg_next.dilation_rows = pwdata[3:0];
                c2i_pkg::REG_DILATION_COLS: cfg_next.dilation_cols = pwdata[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            c2i_pkg::REG_COL_ROWS:      prdata = c2i_pkg::PDATA_W'(cfg_reg.col_rows);
            c2i_pkg::REG_COL_COLS:      prdata = c2i_pkg::PDATA_W'(cfg_reg.col_cols);
            c2i_pkg::REG_PAD_ROWS:      prdata = c2i_pkg::PDATA_W'(cfg_reg.pad_rows);
            c2i_pkg::REG_PAD_COLS:      prdata = c2i_pkg::PDATA_W'(cfg_reg.pad_cols);
            c2i_pkg::REG_STRIDE_ROWS:   prdata = c2i_pkg::PDATA_W'(cfg_reg.stride_rows);
            c2i_pkg::REG_STRIDE_COLS:   prdata = c2i_pkg::PDATA_W'(cfg_reg.stride_cols);
            c2i_pkg::REG_DILATION_ROWS: prdata = c2i_pkg::PDATA_W'(cfg_reg.dilation_rows);
            c2i_pkg::REG_DILATION_COLS: prdata = c2i_pkg::PDATA_W'(cfg_reg.dilation_cols);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col_rows      <= 7'd1;
            cfg_reg.col_cols      <= 7'd1;
            cfg_reg.pad_rows      <= 4'd0;
            cfg_reg.pad_cols      <= 4'd0;
            cfg_reg.stride_rows   <= 4'd1;
            cfg_reg.stride_cols   <= 4'd1;
            cfg_reg.dilation_rows <= 4'd1;
            cfg_reg.dilation_cols <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ===== src/col2im_accumulate.sv =====
// Channel   Handshake                      Payload
// req       req_valid / req_ready          c2i_pkg::req_t (write entry or query pixel)
// rsp       rsp_valid / rsp_ready          c2i_pkg::rsp_t (saturated pixel sum)
// apb       psel / penable / pready        paddr, pwdata, prdata (eight config registers)
//
// A write item gives no result. A query item is accepted, then the per-axis dividers split
// the padded pixel by the stride, the nine kernel taps are read in turn on the single store
// read port, the tap reads drain and the result is loaded. No new item is taken until then.
// The column store is not cleared at reset, so the block takes items right after reset.
// An untaken result lets writes and the next query in; that query then waits in its final
// state and holds off further items.
`include "col2im_accumulate_assert.svh"

module col2im_accumulate (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  c2i_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output c2i_pkg::rsp_t                  rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [c2i_pkg::PADDR_W-1:0]    paddr,
    input  logic [c2i_pkg::PDATA_W-1:0]    pwdata,
    output logic [c2i_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_TAPS  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int SUM_W = c2i_pkg::SUM_W;
    localparam int DW    = c2i_pkg::DATA_WIDTH;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (DW - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (DW - 1)));
    localparam logic signed [DW-1:0]    OUT_HI = DW'((2 ** (DW - 1)) - 1);
    localparam logic signed [DW-1:0]    OUT_LO = DW'(-(2 ** (DW - 1)));

    c2i_pkg::cfg_t cfg;

    logic [2:0] state_reg, state_next;
    logic [c2i_pkg::KR_W-1:0] kr_reg, kr_next;
    logic [c2i_pkg::KC_W-1:0] kc_reg, kc_next;
    logic [1:0] ch_reg, ch_next;
    logic       chq_reg, chq_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_hit_reg, s1_hit_next;
    logic [c2i_pkg::ADDR_W-1:0]    s1_addr_reg, s1_addr_next;
    logic                          s2_valid_reg;
    logic signed [SUM_W-1:0]       acc_reg, acc_next;

    logic          rsp_valid_reg, rsp_valid_next;
    c2i_pkg::rsp_t rsp_reg, rsp_next;

    logic req_fire, query_start, wr_ok, mem_re;
    logic [c2i_pkg::DATA_WIDTH-1:0] mem_rdata;

    logic [c2i_pkg::STEP_W-1:0] sr_eff, sc_eff, dr_eff, dc_eff;
    logic [c2i_pkg::LIM_W-1:0]  rows_eff, cols_eff;
    logic [c2i_pkg::OFF_W-1:0]  offr, offc;
    logic [c2i_pkg::PIX_W-1:0]  row_q, col_q;
    logic [c2i_pkg::STEP_W-1:0] row_r, col_r;
    logic                       row_done, col_done;
    c2i_pkg::tap_pos_t          rt, ct;

    c2i_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req_ready   = (state_reg == ST_IDLE);
    assign req_fire    = req_valid && req_ready;
    assign query_start = req_fire && (req.action == c2i_pkg::ACT_QUERY);
    assign wr_ok = (req.action == c2i_pkg::ACT_WRITE)
                && (int'(req.channel) < c2i_pkg::CHANNELS)
                && (int'(req.kernel_row) < c2i_pkg::KERNEL_ROWS)
                && (int'(req.kernel_col) < c2i_pkg::KERNEL_COLS)
                && (int'(req.col_row) < c2i_pkg::MAX_COL_DIM)
                && (int'(req.col_col) < c2i_pkg::MAX_COL_DIM);

    assign sr_eff = (cfg.stride_rows == '0) ? c2i_pkg::STEP_W'(1) : cfg.stride_rows;
    assign sc_eff = (cfg.stride_cols == '0) ? c2i_pkg::STEP_W'(1) : cfg.stride_cols;
    assign dr_eff = (cfg.dilation_rows == '0) ? c2i_pkg::STEP_W'(1) : cfg.dilation_rows;
    assign dc_eff = (cfg.dilation_cols == '0) ? c2i_pkg::STEP_W'(1) : cfg.dilation_cols;
    assign rows_eff = (int'(cfg.col_rows) > c2i_pkg::MAX_COL_DIM)
                    ? c2i_pkg::LIM_W'(c2i_pkg::MAX_COL_DIM) : c2i_pkg::LIM_W'(cfg.col_rows);
    assign cols_eff = (int'(cfg.col_cols) > c2i_pkg::MAX_COL_DIM)
                    ? c2i_pkg::LIM_W'(c2i_pkg::MAX_COL_DIM) : c2i_pkg::LIM_W'(cfg.col_cols);

    c2i_div u_div_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (query_start),
        .dividend  (c2i_pkg::PIX_W'(req.image_row) + c2i_pkg::PIX_W'(cfg.pad_rows)),
        .divisor   (sr_eff),
        .done      (row_done),
        .quotient  (row_q),
        .remainder (row_r)
    );

    c2i_div u_div_col (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (query_start),
        .dividend  (c2i_pkg::PIX_W'(req.image_col) + c2i_pkg::PIX_W'(cfg.pad_cols)),
        .divisor   (sc_eff),
        .done      (col_done),
        .quotient  (col_q),
        .remainder (col_r)
    );

    assign offr = c2i_pkg::OFF_W'(int'(kr_reg) * int'(dr_eff));
    assign offc = c2i_pkg::OFF_W'(int'(kc_reg) * int'(dc_eff));
    assign rt   = c2i_pkg::dim_tap(row_q, row_r, offr, sr_eff, rows_eff);
    assign ct   = c2i_pkg::dim_tap(col_q, col_r, offc, sc_eff, cols_eff);

    assign mem_re = s1_valid_reg && s1_hit_reg;

    c2i_store u_store (
        .clk   (clk),
        .we    (req_fire && wr_ok),
        .waddr (c2i_pkg::store_addr(int'(req.channel), int'(req.kernel_row),
                                    int'(req.kernel_col), int'(req.col_row),
                                    int'(req.col_col))),
        .wdata (req.entry_value),
        .re    (mem_re),
        .raddr (s1_addr_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        kr_next        = kr_reg;
        kc_next        = kc_reg;
        ch_next        = ch_reg;
        chq_next       = chq_reg;
        s1_valid_next  = 1'b0;
        s1_hit_next    = rt.hit && ct.hit && chq_reg;
        s1_addr_next   = c2i_pkg::store_addr(int'(ch_reg), int'(kr_reg), int'(kc_reg),
                                             int'(rt.pos), int'(ct.pos));
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (s2_valid_reg)
        begin
            acc_next = acc_reg + SUM_W'($signed(mem_rdata));
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                begin
                    state_next = ST_DIV;
                    ch_next    = req.channel;
                    chq_next   = int'(req.channel) < c2i_pkg::CHANNELS;
                end
            end
            ST_DIV:
            begin
                if (row_done && col_done)
                begin
                    state_next = ST_TAPS;
                    kr_next    = '0;
                    kc_next    = '0;
                    acc_next   = '0;
                end
            end
            ST_TAPS:
            begin
                s1_valid_next = 1'b1;
                if (kc_reg == c2i_pkg::KC_W'(c2i_pkg::KERNEL_COLS - 1))
                begin
                    kc_next = '0;
                    kr_next = kr_reg + 1'b1;
                    if (kr_reg == c2i_pkg::KR_W'(c2i_pkg::KERNEL_ROWS - 1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    kc_next = kc_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (acc_reg > SAT_HI)
                    begin
                        rsp_next.pixel_sum = OUT_HI;
                        rsp_next.saturated = 1'b1;
                    end
                    else if (acc_reg < SAT_LO)
                    begin
                        rsp_next.pixel_sum = OUT_LO;
                        rsp_next.saturated = 1'b1;
                    end
                    else
                    begin
                        rsp_next.pixel_sum = acc_reg[DW-1:0];
                        rsp_next.saturated = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kr_reg        <= '0;
            kc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kr_reg        <= kr_next;
            kc_reg        <= kc_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= mem_re;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        chq_reg     <= chq_next;
        s1_hit_reg  <= s1_hit_next;
        s1_addr_reg <= s1_addr_next;
        acc_reg     <= acc_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `C2I_ASSERT_IMPL(a_read_in_taps, mem_re,
        state_reg == ST_TAPS || state_reg == ST_DRAIN, "store read outside the tap phase")
    `C2I_ASSERT_IMPL(a_done_drained, state_reg == ST_DONE,
        !s1_valid_reg && !s2_valid_reg, "result formed before all tap reads returned")
    `C2I_ASSERT_IMPL(a_div_in_div, row_done || col_done,
        state_reg == ST_DIV && row_done && col_done, "divider finished outside its phase")
    `C2I_ASSERT_IMPL(a_sat_clipped, rsp_valid_reg && rsp_reg.saturated,
        rsp_reg.pixel_sum == OUT_HI || rsp_reg.pixel_sum == OUT_LO,
        "saturated result that is not at a rail")

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] kr;
        logic [1:0] kc;
        logic [5:0] r;
        logic [5:0] c;
    } tap_t;

    typedef struct packed {
        logic          is_cfg;
        logic [2:0]    reg_idx;
        logic [6:0]    reg_val;
        logic          typed;
        c2i_pkg::rsp_t want;
        c2i_pkg::req_t item;
    } script_row_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    c2i_pkg::req_t                 req = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    c2i_pkg::rsp_t                 rsp;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [c2i_pkg::PADDR_W-1:0]   paddr = '0;
    logic [c2i_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [c2i_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    shortint       col_mem [c2i_pkg::STORE_DEPTH];
    bit            col_seen [c2i_pkg::STORE_DEPTH];
    c2i_pkg::cfg_t shape;
    c2i_pkg::rsp_t pending_sums[$];
    c2i_pkg::rsp_t head_sum;
    script_row_t   script[$];
    int            mismatches = 0;
    int            items_done = 0;
    int            stuck = 0;
    bit            steady = 1'b0;

    col2im_accumulate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %h, got %h", what, want, got);
    endfunction

    function automatic int slot(input int ch, input int kr, input int kc, input int r,
                                input int c);
        return (((ch * c2i_pkg::KERNEL_ROWS + kr) * c2i_pkg::KERNEL_COLS + kc)
                * c2i_pkg::MAX_COL_DIM + r) * c2i_pkg::MAX_COL_DIM + c;
    endfunction

    function automatic int eff_dim(input int v);
        return (v > c2i_pkg::MAX_COL_DIM) ? c2i_pkg::MAX_COL_DIM : v;
    endfunction

    function automatic int eff_step(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        return (idx == c2i_pkg::REG_COL_ROWS || idx == c2i_pkg::REG_COL_COLS)
               ? 32'h7f : 32'hf;
    endfunction

    // Every kernel tap whose window covers the padded pixel on a stride step.
    function automatic void list_taps(input logic [1:0] ch, input logic [9:0] row,
                                      input logic [9:0] col, output tap_t hits[$]);
        int   rows;
        int   cols;
        int   sr;
        int   sc;
        int   dr;
        int   dc;
        int   tr;
        int   tc;
        tap_t one;
        rows = eff_dim(shape.col_rows);
        cols = eff_dim(shape.col_cols);
        sr   = eff_step(shape.stride_rows);
        sc   = eff_step(shape.stride_cols);
        dr   = eff_step(shape.dilation_rows);
        dc   = eff_step(shape.dilation_cols);
        hits = {};
        if (ch >= c2i_pkg::CHANNELS)
            return;
        for (int kr = 0; kr < c2i_pkg::KERNEL_ROWS; kr++)
        begin
            tr = int'(row) + int'(shape.pad_rows) - kr * dr;
            if (tr < 0 || tr % sr != 0 || tr / sr >= rows)
                continue;
            for (int kc = 0; kc < c2i_pkg::KERNEL_COLS; kc++)
            begin
                tc = int'(col) + int'(shape.pad_cols) - kc * dc;
                if (tc < 0 || tc % sc != 0 || tc / sc >= cols)
                    continue;
                one.kr = 2'(kr);
                one.kc = 2'(kc);
                one.r  = 6'(tr / sr);
                one.c  = 6'(tc / sc);
                hits.push_back(one);
            end
        end
    endfunction

    function automatic c2i_pkg::rsp_t clip_sum(input int total);
        c2i_pkg::rsp_t res;
        res.saturated = 1'b0;
        if (total > 32767)
        begin
            total = 32767;
            res.saturated = 1'b1;
        end
        else if (total < -32768)
        begin
            total = -32768;
            res.saturated = 1'b1;
        end
        res.pixel_sum = 16'(total);
        return res;
    endfunction

    function automatic c2i_pkg::req_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(c2i_pkg::req_t)-1:0];
    endfunction

    function automatic logic [15:0] pick_value();
        int mode;
        mode = $urandom_range(99);
        if (mode < 10)
            return $urandom_range(1) ? 16'h7fff : 16'h8000;
        if (mode < 55)
            return 16'($urandom_range(0, 4000) - 2000);
        return 16'($urandom);
    endfunction

    function automatic logic [9:0] pick_coord(input int span, input int step, input int dil,
                                              input int pad, input int kdim);
        int mode;
        int p;
        int reach;
        mode  = $urandom_range(99);
        reach = span * step + (kdim - 1) * dil;
        if (reach > 1023)
            reach = 1023;
        if (mode < 60 && span > 0)
        begin
            p = $urandom_range(0, span - 1) * step + $urandom_range(0, kdim - 1) * dil;
            return (p >= pad) ? 10'(p - pad) : 10'(0);
        end
        if (mode < 85)
            return 10'($urandom_range(0, reach));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic c2i_pkg::req_t make_write(input logic [1:0] ch, input logic [1:0] kr,
                                                 input logic [1:0] kc, input logic [5:0] r,
                                                 input logic [5:0] c, input logic [15:0] v);
        c2i_pkg::req_t it;
        it             = random_item();
        it.action      = c2i_pkg::ACT_WRITE;
        it.channel     = ch;
        it.kernel_row  = kr;
        it.kernel_col  = kc;
        it.col_row     = r;
        it.col_col     = c;
        it.entry_value = v;
        return it;
    endfunction

    function automatic c2i_pkg::req_t make_query(input logic [1:0] ch, input logic [9:0] row,
                                                 input logic [9:0] col);
        c2i_pkg::req_t it;
        it           = random_item();
        it.action    = c2i_pkg::ACT_QUERY;
        it.channel   = ch;
        it.image_row = row;
        it.image_col = col;
        return it;
    endfunction

    function automatic script_row_t wr(input logic [1:0] ch, input logic [1:0] kr,
                                       input logic [1:0] kc, input logic [5:0] r,
                                       input logic [5:0] c, input logic [15:0] v);
        script_row_t s;
        s      = '0;
        s.item = make_write(ch, kr, kc, r, c, v);
        return s;
    endfunction

    function automatic script_row_t qr(input logic [1:0] ch, input logic [9:0] row,
                                       input logic [9:0] col);
        script_row_t s;
        s      = '0;
        s.item = make_query(ch, row, col);
        return s;
    endfunction

    function automatic script_row_t qt(input logic [1:0] ch, input logic [9:0] row,
                                       input logic [9:0] col, input logic [15:0] sum,
                                       input logic sat);
        script_row_t s;
        s                = qr(ch, row, col);
        s.typed          = 1'b1;
        s.want.pixel_sum = sum;
        s.want.saturated = sat;
        return s;
    endfunction

    function automatic script_row_t cf(input logic [2:0] idx, input logic [6:0] val);
        script_row_t s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic c2i_pkg::cfg_t phase_shape(input int p);
        c2i_pkg::cfg_t s;
        s.col_rows      = 7'($urandom_range(1, 12));
        s.col_cols      = 7'($urandom_range(1, 12));
        s.pad_rows      = 4'($urandom_range(0, 15));
        s.pad_cols      = 4'($urandom_range(0, 15));
        s.stride_rows   = 4'($urandom_range(0, 15));
        s.stride_cols   = 4'($urandom_range(0, 15));
        s.dilation_rows = 4'($urandom_range(0, 15));
        s.dilation_cols = 4'($urandom_range(0, 15));
        case (p)
            1:
            begin
                s = '{7'd127, 7'd64, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
            end
            2:
            begin
                s = '{7'd64, 7'd127, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1};
            end
            3:
            begin
                s.stride_rows   = 4'd0;
                s.stride_cols   = 4'd0;
                s.dilation_rows = 4'd0;
                s.dilation_cols = 4'd0;
            end
            9:
            begin
                s.col_rows = 7'd127;
                s.col_cols = 7'd0;
            end
            default:
            begin
            end
        endcase
        return s;
    endfunction

    task automatic push_item(input c2i_pkg::req_t it);
        if (!steady && $urandom_range(99) < 25)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic send_write(input c2i_pkg::req_t it);
        push_item(it);
        if (it.channel < c2i_pkg::CHANNELS && it.kernel_row < c2i_pkg::KERNEL_ROWS &&
            it.kernel_col < c2i_pkg::KERNEL_COLS)
        begin
            col_mem[slot(it.channel, it.kernel_row, it.kernel_col, it.col_row, it.col_col)]
                = it.entry_value;
            col_seen[slot(it.channel, it.kernel_row, it.kernel_col, it.col_row, it.col_col)]
                = 1'b1;
            items_done++;
        end
    endtask

    // Entries the query will read are written first if they were never written.
    task automatic send_query(input c2i_pkg::req_t it, input bit typed,
                              input c2i_pkg::rsp_t want);
        tap_t hits[$];
        int   total;
        list_taps(it.channel, it.image_row, it.image_col, hits);
        foreach (hits[i])
            if (!col_seen[slot(it.channel, hits[i].kr, hits[i].kc, hits[i].r, hits[i].c)])
                send_write(make_write(it.channel, hits[i].kr, hits[i].kc, hits[i].r,
                                      hits[i].c, pick_value()));
        push_item(it);
        total = 0;
        foreach (hits[i])
            total += col_mem[slot(it.channel, hits[i].kr, hits[i].kc, hits[i].r, hits[i].c)];
        pending_sums.push_back(typed ? want : clip_sum(total));
        items_done++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_sums.size() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_update(input logic [2:0] idx, input logic [31:0] value,
                              input bit scramble);
        logic [31:0] mask;
        logic [31:0] wdata;
        logic [31:0] kept;
        mask    = reg_mask(idx);
        wdata   = scramble ? (($urandom & ~mask) | (value & mask)) : value;
        kept    = wdata & mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            c2i_pkg::REG_COL_ROWS:      shape.col_rows      = kept[6:0];
            c2i_pkg::REG_COL_COLS:      shape.col_cols      = kept[6:0];
            c2i_pkg::REG_PAD_ROWS:      shape.pad_rows      = kept[3:0];
            c2i_pkg::REG_PAD_COLS:      shape.pad_cols      = kept[3:0];
            c2i_pkg::REG_STRIDE_ROWS:   shape.stride_rows   = kept[3:0];
            c2i_pkg::REG_STRIDE_COLS:   shape.stride_cols   = kept[3:0];
            c2i_pkg::REG_DILATION_ROWS: shape.dilation_rows = kept[3:0];
            c2i_pkg::REG_DILATION_COLS: shape.dilation_cols = kept[3:0];
            default:
            begin
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== kept)
            note_mismatch($sformatf("register %0d readback", idx), kept, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_shape(input c2i_pkg::cfg_t next);
        reg_update(c2i_pkg::REG_COL_ROWS, 32'(next.col_rows), 1'b1);
        reg_update(c2i_pkg::REG_COL_COLS, 32'(next.col_cols), 1'b1);
        reg_update(c2i_pkg::REG_PAD_ROWS, 32'(next.pad_rows), 1'b1);
        reg_update(c2i_pkg::REG_PAD_COLS, 32'(next.pad_cols), 1'b1);
        reg_update(c2i_pkg::REG_STRIDE_ROWS, 32'(next.stride_rows), 1'b1);
        reg_update(c2i_pkg::REG_STRIDE_COLS, 32'(next.stride_cols), 1'b1);
        reg_update(c2i_pkg::REG_DILATION_ROWS, 32'(next.dilation_rows), 1'b1);
        reg_update(c2i_pkg::REG_DILATION_COLS, 32'(next.dilation_cols), 1'b1);
    endtask

    always @(posedge clk)
        rsp_ready <= steady || ($urandom_range(99) >= 25);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_sums.size() == 0)
                note_mismatch("result with nothing pending", '0, 32'(rsp));
            else
            begin
                head_sum = pending_sums.pop_front();
                if (rsp.pixel_sum !== head_sum.pixel_sum)
                    note_mismatch("pixel_sum", 32'(head_sum.pixel_sum), 32'(rsp.pixel_sum));
                if (rsp.saturated !== head_sum.saturated)
                    note_mismatch("saturated", 32'(head_sum.saturated), 32'(rsp.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck == STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int            target;
        bit            paused;
        c2i_pkg::req_t noise;
        shape  = '{7'd1, 7'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1};
        paused = 1'b0;

        script.push_back(wr(2'd0, 2'd0, 2'd0, 6'd0, 6'd0, 16'h7fff));
        script.push_back(qt(2'd0, 10'd0, 10'd0, 16'h7fff, 1'b0));
        script.push_back(wr(2'd3, 2'd2, 2'd2, 6'd0, 6'd0, 16'h8000));
        script.push_back(qt(2'd3, 10'd2, 10'd2, 16'h8000, 1'b0));
        script.push_back(qt(2'd2, 10'd1023, 10'd1023, 16'h0000, 1'b0));
        script.push_back(wr(2'd3, 2'd3, 2'd2, 6'd0, 6'd0, 16'h1234));
        script.push_back(wr(2'd3, 2'd2, 2'd3, 6'd0, 6'd0, 16'h4321));
        script.push_back(wr(2'd2, 2'd1, 2'd1, 6'd63, 6'd63, 16'h0155));
        script.push_back(qt(2'd3, 10'd2, 10'd2, 16'h8000, 1'b0));
        script.push_back(cf(c2i_pkg::REG_COL_ROWS, 7'd0));
        script.push_back(qt(2'd0, 10'd0, 10'd0, 16'h0000, 1'b0));
        script.push_back(cf(c2i_pkg::REG_COL_ROWS, 7'd2));
        script.push_back(cf(c2i_pkg::REG_STRIDE_ROWS, 7'd0));
        script.push_back(cf(c2i_pkg::REG_DILATION_ROWS, 7'd0));
        script.push_back(wr(2'd1, 2'd0, 2'd0, 6'd1, 6'd0, 16'h7fff));
        script.push_back(wr(2'd1, 2'd1, 2'd0, 6'd0, 6'd0, 16'h7fff));
        script.push_back(qt(2'd1, 10'd1, 10'd0, 16'h7fff, 1'b1));
        script.push_back(wr(2'd1, 2'd0, 2'd0, 6'd1, 6'd0, 16'h8000));
        script.push_back(wr(2'd1, 2'd1, 2'd0, 6'd0, 6'd0, 16'h8000));
        script.push_back(qt(2'd1, 10'd1, 10'd0, 16'h8000, 1'b1));
        script.push_back(cf(c2i_pkg::REG_COL_ROWS, 7'd127));
        script.push_back(qt(2'd1, 10'd1, 10'd0, 16'h8000, 1'b1));
        script.push_back(qr(2'd0, 10'd5, 10'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                reg_update(script[i].reg_idx, 32'(script[i].reg_val), 1'b0);
            end
            else if (script[i].item.action == c2i_pkg::ACT_WRITE)
                send_write(script[i].item);
            else
                send_query(script[i].item, script[i].typed, script[i].want);
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            settle();
            load_shape(phase_shape(phase));
            steady = (phase == 4);
            target = items_done + 118;
            while (items_done < target)
            begin
                if (phase == 6 && !paused && items_done >= target - 60)
                begin
                    drain();
                    paused = 1'b1;
                end
                case ($urandom_range(99)) inside
                    [0:9]:
                    begin
                        noise        = random_item();
                        noise.action = c2i_pkg::ACT_WRITE;
                        send_write(noise);
                    end
                    [10:24]:
                        send_write(make_write(2'($urandom_range(0, 3)),
                                              2'($urandom_range(0, 2)),
                                              2'($urandom_range(0, 2)),
                                              6'($urandom_range(0, 63)),
                                              6'($urandom_range(0, 63)), pick_value()));
                    default:
                        send_query(make_query(2'($urandom_range(0, c2i_pkg::CHANNELS - 1)),
                                              pick_coord(eff_dim(shape.col_rows),
                                                         eff_step(shape.stride_rows),
                                                         eff_step(shape.dilation_rows),
                                                         shape.pad_rows,
                                                         c2i_pkg::KERNEL_ROWS),
                                              pick_coord(eff_dim(shape.col_cols),
                                                         eff_step(shape.stride_cols),
                                                         eff_step(shape.dilation_cols),
                                                         shape.pad_cols,
                                                         c2i_pkg::KERNEL_COLS)),
                                   1'b0, '0);
                endcase
            end
        end
        steady = 1'b0;

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
